### rtl/sflf_pkg.sv
// Shared types and constants for the substring first/last finder.
// No dependencies; imported by sflf_cell and substring_first_last_finder.
`timescale 1ns / 1ps

package sflf_pkg;

    localparam int PAT_BYTES   = 16;   // bytes held by the two pattern registers
    localparam int LEN_W       = 5;    // width of pattern_length
    localparam int START_W     = 16;   // width of match_start
    localparam int START_MAX   = 65535;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    typedef logic [7:0] t_byte;
    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_FIND_MODE    = 2'd3
    } t_cfg_reg;

endpackage

### rtl/sflf_cell.sv
// One window cell: holds a text byte, passes it to the next older cell,
// and compares it against the pattern byte aligned to its slot. Uses sflf_pkg.
`timescale 1ns / 1ps

module sflf_cell
    import sflf_pkg::*;
#(
    parameter int K = 0                     // slot, 0 is the newest byte
) (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_byte,                   // from the newer neighbor
    input  t_byte i_pattern [PAT_BYTES],
    input  t_len  i_len,
    output t_byte o_byte,                   // to the older neighbor
    output logic  o_hit
);

    t_byte      r_byte;
    logic [3:0] pat_idx;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // slot K lines up with pattern byte len-1-K; slots past the length agree
    assign pat_idx = 4'(i_len - LEN_W'(K) - LEN_W'(1));
    assign o_hit   = (LEN_W'(K) >= i_len) || (r_byte == i_pattern[pat_idx]);
    assign o_byte  = r_byte;

endmodule

### rtl/substring_first_last_finder.sv
// Top level of the substring first/last finder: position tracking, match
// bookkeeping and result register around a row of sflf_cell. Uses sflf_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input stream: one text byte per transfer on s_axis (tdata = text_byte),
//   tlast marks the final byte of a text. One byte is taken every cycle while o_s_axis_tready is high.
//   Output stream: one result per text on m_axis, after the tlast transfer.
//   The result register is loaded from the compare stage: the tlast transfer
//   shifts the byte into the cell row, and the window compare is registered
//   into the result register once the compare stage advances.
//   Throughput is one byte per cycle while the input is not stalled, set by the
//   shift of the cell row and the parallel compare of all cells against the pattern.
//   While a result waits in the output register, bytes keep flowing; only a
//   second tlast byte reaching the compare stage stalls the input, and
//   o_s_axis_tready drops until the waiting result is taken.
//   Configuration: write pattern_low/high, pattern_length and find_mode
//   through i_cfg_* while the block is idle. Pattern length 0 never matches.
//   Reset (synchronous, active low) clears the registers, position and
//   pending results; the window needs no clearing since a match also
//   requires pattern_length bytes of the current text.
//   Texts over MAX_TEXT bytes report too_long; later bytes are not searched.

module substring_first_last_finder
    import sflf_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // text stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] text_byte
    input  logic                  i_s_axis_tlast,   // end_of_text
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata    // [0] found, [16:1] match_start,
                                                    // [17] too_long, [23:18] zero
);

    localparam int POS_W = $clog2(MAX_TEXT + 2);

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    t_len                  r_len;
    logic                  r_mode;
    t_byte                 pattern [PAT_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= '0;
            r_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PATTERN_LOW:  r_pat_low  <= i_cfg_wdata;
                REG_PATTERN_HIGH: r_pat_high <= i_cfg_wdata;
                REG_PATTERN_LEN:  r_len      <= i_cfg_wdata[LEN_W-1:0];
                REG_FIND_MODE:    r_mode     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < PAT_BYTES / 2; j++) begin
            pattern[j]                 = r_pat_low[j*8 +: 8];
            pattern[j + PAT_BYTES / 2] = r_pat_high[j*8 +: 8];
        end
    end

    // handshake
    logic s_accept;
    logic advance;
    logic r_p_valid;
    logic r_p_last;
    logic r_out_valid;

    assign advance         = !(r_p_valid && r_p_last && r_out_valid && !i_m_axis_tready);
    assign o_s_axis_tready = advance;
    assign s_accept        = i_s_axis_tvalid && advance;

    // stage 0: position count and window shift
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             in_range;
    logic [POS_W-1:0] r_p_pos;
    logic             r_p_search;

    assign in_range = 32'(r_pos) < 32'(MAX_TEXT);
    assign n_pos    = in_range ? r_pos + POS_W'(1) : POS_W'(MAX_TEXT + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_pos <= i_s_axis_tlast ? '0 : n_pos;
            end
            if (advance) begin
                r_p_valid <= s_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_p_pos    <= n_pos;
            r_p_search <= in_range;
            r_p_last   <= i_s_axis_tlast;
        end
    end

    // cell row
    t_byte                  chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;

    assign chain[0] = i_s_axis_tdata;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        sflf_cell #(.K(k)) u_cell (
            .i_clk     (i_clk),
            .i_shift   (s_accept && in_range),
            .i_byte    (chain[k]),
            .i_pattern (pattern),
            .i_len     (r_len),
            .o_byte    (chain[k+1]),
            .o_hit     (hits[k])
        );
    end

    // stage 1: compare and keep the first or last match
    logic               hit;
    logic [POS_W-1:0]   start_full;
    logic [START_W-1:0] start;
    logic               upd;
    logic               r_have;
    logic [START_W-1:0] r_kept;
    logic               n_have;
    logic [START_W-1:0] n_kept;
    logic [23:0]        r_out_data;

    assign hit = r_p_search && (r_len != '0) && (32'(r_len) <= 32'(MAX_PATTERN))
              && (32'(r_p_pos) >= 32'(r_len)) && (&hits);
    assign start_full = r_p_pos - POS_W'(r_len);
    assign start = (32'(start_full) > 32'(START_MAX)) ? START_W'(START_MAX)
                                                       : START_W'(start_full);
    assign upd    = hit && (r_mode || !r_have);
    assign n_have = upd || r_have;
    assign n_kept = upd ? start : r_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_p_valid && advance) begin
                if (r_p_last) begin
                    r_have <= 1'b0;
                    r_kept <= '0;
                end else begin
                    r_have <= n_have;
                    r_kept <= n_kept;
                end
            end
            if (r_p_valid && advance && r_p_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && advance && r_p_last) begin
            r_out_data <= {6'd0,
                           32'(r_p_pos) > 32'(MAX_TEXT),
                           n_have ? n_kept : START_W'(0),
                           n_have};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= 32'(MAX_TEXT + 1))
        else $error("byte position beyond saturation value");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tlast) |=> (r_pos == '0))
        else $error("position not cleared after end of text");

    a_kept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_kept == '0))
        else $error("kept start set without a match");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_out_valid && r_p_valid && r_p_last))
        else $error("input stalled without a waiting result");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[16:1] == '0))
        else $error("match_start nonzero without a match");

endmodule
